// ===== src/stq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer queue: request kinds,
// status codes, the entry held by each cell and the command sent down the row.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] INFINITE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_PROCESS = 2'd2,
        KIND_QUERY   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_NONE_DUE  = 2'd3
    } t_status;

    // Row operations applied by every cell in the same cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_POPINS = 2'd3
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DEL,
        ST_REMR,
        ST_PROC
    } t_state;

    typedef struct packed {
        logic [31:0] trig;
        logic [31:0] per;
        logic        once;
        logic [31:0] id;
    } t_entry;

    typedef struct packed {
        t_cell_op    op;
        t_entry      ent;
        logic [31:0] tid;
    } t_cell_cmd;

    localparam t_entry EMPTY_ENTRY = '0;

endpackage
`default_nettype wire

// ===== src/stq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted row. Holds a timer entry and moves it to or from a
// neighbor for insert, pop and pop-with-reinsert; a delete token walks the
// row one cell per cycle and closes the gap behind the matching entry.
// ----------------------------------------------------------------------------
module stq_cell #(
    parameter int CAPACITY = 16,
    parameter int IDX      = 0
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  stq_pkg::t_cell_cmd            i_cmd,
    input  wire [$clog2(CAPACITY+1)-1:0]  i_count,
    input  stq_pkg::t_entry               i_left,
    input  wire                           i_left_go,
    input  stq_pkg::t_entry               i_right,
    input  wire                           i_right_go,
    input  wire                           i_tok,
    input  wire                           i_fnd,
    output stq_pkg::t_entry               o_entry,
    output logic                          o_go,
    output logic                          o_tok,
    output logic                          o_fnd
);
    import stq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_entry r_ent;
    t_entry n_ent;
    logic   r_tok;
    logic   r_fnd;
    logic   occ;
    logic   go;
    logic   hit;
    logic   gl_pop;

    // occupancy and insert position flag
    assign occ    = CW'(IDX) < i_count;
    assign go     = !occ || (i_cmd.ent.trig < r_ent.trig);
    assign hit    = i_fnd || (occ && (r_ent.id == i_cmd.tid));
    assign gl_pop = (IDX == 0) ? 1'b0 : go;

    // select next entry
    always_comb begin
        n_ent = r_ent;
        if (i_tok) begin
            if (hit) begin
                n_ent = i_right;
            end
        end else begin
            unique case (i_cmd.op)
                OP_HOLD: begin
                    n_ent = r_ent;
                end
                OP_INSERT: begin
                    if (go && !i_left_go) begin
                        n_ent = i_cmd.ent;
                    end else if (go) begin
                        n_ent = i_left;
                    end
                end
                OP_POP: begin
                    n_ent = i_right;
                end
                OP_POPINS: begin
                    // row shifted left by one, then the new entry goes in
                    if (i_right_go && !gl_pop) begin
                        n_ent = i_cmd.ent;
                    end else if (!i_right_go) begin
                        n_ent = i_right;
                    end
                end
                default: begin
                    n_ent = r_ent;
                end
            endcase
        end
    end

    // hold entry
    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_fnd <= hit;
    end

    // advance delete token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    assign o_entry = r_ent;
    assign o_go    = go;
    assign o_tok   = r_tok;
    assign o_fnd   = r_fnd;

endmodule
`default_nettype wire

// ===== src/sorted_timer_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer table kept sorted by trigger time in a row of cells.
// ----------------------------------------------------------------------------
// Requests enter on i_valid/o_stall, results leave on o_valid/i_stall from an
// output register. One request is worked on at a time; o_stall is high from
// acceptance until the last result of that request has been loaded.
// Add and query capture the request, then insert in parallel across the row
// or read the head cell once the output register is free.
// Remove sends a delete token through every cell, one per cycle, shifting
// the entries behind the match left.
// Process pops the head cell for each firing and reinserts a periodic timer
// in the same cycle. A fired result is held back so its last flag is known
// before it is sent.
// Add and reinsert cost one compare per cell; the trigger sum is formed once.
// Reset clears the entry count and the ID counter; cell contents are not
// cleared and need no clearing pass.
// While the receiver stalls, the output register holds its result and the
// block pauses before loading the next one.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
    parameter int CAPACITY = stq_pkg::DEF_CAPACITY
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_kind,
    input  wire  [31:0] i_now,
    input  wire  [31:0] i_interval,
    input  wire         i_once_only,
    input  wire  [31:0] i_timer_id,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_id,
    output logic        o_fired,
    output logic [31:0] o_wait_time,
    output logic        o_queue_empty,
    output logic        o_last
);
    import stq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // control state
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [31:0]       r_last_id, n_last_id;
    logic [RES_W-1:0]  r_left, n_left;
    logic              r_pend_v, n_pend_v;
    logic              r_ov, n_ov;

    // request and result payload
    t_kind             r_req_kind;
    logic [31:0]       r_req_now;
    logic [31:0]       r_req_ival;
    logic              r_req_once;
    logic [31:0]       r_req_tid;
    logic [31:0]       r_new_trig;
    logic [31:0]       r_pend_id, n_pend_id;
    logic              r_pend_empty, n_pend_empty;
    logic              r_found, n_found;
    t_status           r_o_status, n_o_status;
    logic [31:0]       r_o_id, n_o_id;
    logic              r_o_fired, n_o_fired;
    logic [31:0]       r_o_wait, n_o_wait;
    logic              r_o_empty, n_o_empty;
    logic              r_o_last, n_o_last;

    // row wiring
    t_cell_cmd         cmd;
    logic              del_start;
    t_entry            c_ent [CAPACITY];
    logic [CAPACITY-1:0] c_go;
    logic [CAPACITY-1:0] c_tok;
    logic [CAPACITY-1:0] c_fnd;

    logic              in_acc;
    logic              o_free;
    t_entry            head;
    logic              head_due;
    logic              due;
    logic [31:0]       per_fix;
    logic [31:0]       re_trig;

    assign in_acc   = i_valid && !o_stall;
    assign o_free   = !r_ov || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign head     = c_ent[0];
    assign head_due = head.trig <= r_req_now;
    assign per_fix  = (head.per == 32'd0) ? 32'd1 : head.per;
    assign re_trig  = r_req_now + per_fix;
    assign due      = (r_left != '0) && (r_count != '0) && head_due;

    // next state, row command and result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_last_id    = r_last_id;
        n_left       = r_left;
        n_pend_v     = r_pend_v;
        n_pend_id    = r_pend_id;
        n_pend_empty = r_pend_empty;
        n_found      = r_found;
        n_ov         = r_ov && i_stall;
        n_o_status   = r_o_status;
        n_o_id       = r_o_id;
        n_o_fired    = r_o_fired;
        n_o_wait     = r_o_wait;
        n_o_empty    = r_o_empty;
        n_o_last     = r_o_last;
        del_start    = 1'b0;
        cmd.op       = OP_HOLD;
        cmd.tid      = r_req_tid;
        cmd.ent.trig = r_new_trig;
        cmd.ent.per  = r_req_ival;
        cmd.ent.once = r_req_once;
        cmd.ent.id   = r_last_id + 32'd1;
        if (r_state == ST_PROC) begin
            cmd.ent.trig = re_trig;
            cmd.ent.per  = per_fix;
            cmd.ent.once = 1'b0;
            cmd.ent.id   = head.id;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_pend_v = 1'b0;
                    n_left   = (32'(r_count) > 32'(MAX_RESULTS)) ?
                               RES_W'(MAX_RESULTS) : RES_W'(r_count);
                    n_state  = (t_kind'(i_kind) == KIND_PROCESS) ? ST_PROC : ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_req_kind)
                    KIND_ADD: begin
                        if (o_free) begin
                            n_ov      = 1'b1;
                            n_o_fired = 1'b0;
                            n_o_wait  = 32'd0;
                            n_o_last  = 1'b1;
                            if (r_count == CW'(CAPACITY)) begin
                                n_o_status = STATUS_FULL;
                                n_o_id     = 32'd0;
                                n_o_empty  = 1'b0;
                            end else begin
                                cmd.op     = OP_INSERT;
                                n_count    = r_count + CW'(1);
                                n_last_id  = r_last_id + 32'd1;
                                n_o_status = STATUS_OK;
                                n_o_id     = r_last_id + 32'd1;
                                n_o_empty  = 1'b0;
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    KIND_REMOVE: begin
                        del_start = 1'b1;
                        n_state   = ST_DEL;
                    end
                    KIND_QUERY: begin
                        if (o_free) begin
                            n_ov       = 1'b1;
                            n_o_status = STATUS_OK;
                            n_o_id     = 32'd0;
                            n_o_fired  = 1'b0;
                            n_o_empty  = (r_count == '0);
                            n_o_last   = 1'b1;
                            if (r_count == '0) begin
                                n_o_wait = INFINITE;
                            end else if (head_due) begin
                                n_o_wait = 32'd0;
                            end else begin
                                n_o_wait = head.trig - r_req_now;
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    KIND_PROCESS: begin
                        n_state = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_DEL: begin
                // wait for the token to leave the last cell
                if (c_tok[CAPACITY-1]) begin
                    n_found = c_fnd[CAPACITY-1];
                    if (c_fnd[CAPACITY-1]) begin
                        n_count = r_count - CW'(1);
                    end
                    n_state = ST_REMR;
                end
            end
            ST_REMR: begin
                if (o_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_found ? STATUS_OK : STATUS_NOT_FOUND;
                    n_o_id     = 32'd0;
                    n_o_fired  = 1'b0;
                    n_o_wait   = 32'd0;
                    n_o_empty  = (r_count == '0);
                    n_o_last   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_PROC: begin
                if (o_free) begin
                    n_o_status = STATUS_OK;
                    n_o_wait   = 32'd0;
                    if (due) begin
                        // send the held firing, then fire the head
                        if (r_pend_v) begin
                            n_ov      = 1'b1;
                            n_o_id    = r_pend_id;
                            n_o_fired = 1'b1;
                            n_o_empty = r_pend_empty;
                            n_o_last  = 1'b0;
                        end
                        n_pend_v  = 1'b1;
                        n_pend_id = head.id;
                        n_left    = r_left - RES_W'(1);
                        if (head.once) begin
                            cmd.op       = OP_POP;
                            n_count      = r_count - CW'(1);
                            n_pend_empty = (r_count == CW'(1));
                        end else begin
                            cmd.op       = OP_POPINS;
                            n_pend_empty = 1'b0;
                        end
                    end else begin
                        n_ov     = 1'b1;
                        n_o_last = 1'b1;
                        if (r_pend_v) begin
                            n_o_id    = r_pend_id;
                            n_o_fired = 1'b1;
                            n_o_empty = r_pend_empty;
                        end else begin
                            n_o_status = STATUS_NONE_DUE;
                            n_o_id     = 32'd0;
                            n_o_fired  = 1'b0;
                            n_o_empty  = (r_count == '0);
                        end
                        n_pend_v = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_last_id <= 32'd0;
            r_left    <= '0;
            r_pend_v  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_last_id <= n_last_id;
            r_left    <= n_left;
            r_pend_v  <= n_pend_v;
            r_ov      <= n_ov;
        end
    end

    // capture request and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req_kind <= t_kind'(i_kind);
            r_req_now  <= i_now;
            r_req_ival <= i_interval;
            r_req_once <= i_once_only;
            r_req_tid  <= i_timer_id;
            r_new_trig <= i_now + i_interval;
        end
        r_pend_id    <= n_pend_id;
        r_pend_empty <= n_pend_empty;
        r_found      <= n_found;
        r_o_status   <= n_o_status;
        r_o_id       <= n_o_id;
        r_o_fired    <= n_o_fired;
        r_o_wait     <= n_o_wait;
        r_o_empty    <= n_o_empty;
        r_o_last     <= n_o_last;
    end

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry left_ent;
        t_entry right_ent;
        logic   left_go;
        logic   right_go;
        logic   tok_in;
        logic   fnd_in;

        if (g == 0) begin : g_first
            assign left_ent = EMPTY_ENTRY;
            assign left_go  = 1'b0;
            assign tok_in   = del_start;
            assign fnd_in   = 1'b0;
        end else begin : g_mid
            assign left_ent = c_ent[g-1];
            assign left_go  = c_go[g-1];
            assign tok_in   = c_tok[g-1];
            assign fnd_in   = c_fnd[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign right_ent = EMPTY_ENTRY;
            assign right_go  = 1'b1;
        end else begin : g_inner
            assign right_ent = c_ent[g+1];
            assign right_go  = c_go[g+1];
        end

        stq_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_count    (r_count),
            .i_left     (left_ent),
            .i_left_go  (left_go),
            .i_right    (right_ent),
            .i_right_go (right_go),
            .i_tok      (tok_in),
            .i_fnd      (fnd_in),
            .o_entry    (c_ent[g]),
            .o_go       (c_go[g]),
            .o_tok      (c_tok[g]),
            .o_fnd      (c_fnd[g])
        );
    end

    assign o_valid       = r_ov;
    assign o_status      = r_o_status;
    assign o_result_id   = r_o_id;
    assign o_fired       = r_o_fired;
    assign o_wait_time   = r_o_wait;
    assign o_queue_empty = r_o_empty;
    assign o_last        = r_o_last;

    // entry count stays within the row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // only one delete token in the row
    a_tok_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(c_tok))
        else $error("more than one delete token");

    // a token only walks during a remove
    a_tok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_tok != '0) |-> (r_state == ST_DEL))
        else $error("delete token outside remove");

    // head pair stays in trigger order
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (c_ent[0].trig <= c_ent[1].trig))
        else $error("row out of order at head");

endmodule
`default_nettype wire
